/* design/apab_pkg.sv */
// Shared constants, types and the alpha-to-weight function for the ARGB alpha blend core.
`default_nettype none
package apab_pkg;

    localparam int NumStages = 6;

    localparam int ChanW   = 8;
    localparam int RgbW    = 24;
    localparam int PixW    = 32;
    localparam int CoordW  = 10;
    localparam int PctW    = 7;
    localparam int WidthW  = 11;
    localparam int IdxW    = 20;
    localparam int KW      = 7;
    localparam int AlphaPW = ChanW + PctW;
    localparam int SumW    = 10;

    localparam int SDataW   = 96;
    localparam int SUserW   = 2;
    localparam int MDataW   = 56;
    localparam int MUserW   = 1;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    localparam int FullScale = 255;
    localparam int Percent   = 100;

    // floor(v/100) == (v*41944) >> 22 for every v below 43690
    localparam logic [15:0] RecipPct   = 16'd41944;
    localparam int          RecipPctSh = 22;
    // floor(v/3) == (v*683) >> 11 for every v up to 765
    localparam logic [9:0]  RecipThird   = 10'd683;
    localparam int          RecipThirdSh = 11;
    // floor(v/255) == (v*32897) >> 23 for every v below 66052
    localparam logic [15:0] RecipFull   = 16'd32897;
    localparam int          RecipFullSh = 23;

    localparam logic [WidthW-1:0] LineWidthRst = 11'd240;
    localparam logic [ChanW-1:0]  AlphaOpaque  = 8'hFF;

    typedef enum logic [CfgIdxW-1:0] {
        CfgSolidBg   = 2'd0,
        CfgBgColor   = 2'd1,
        CfgLineWidth = 2'd2,
        CfgDrawBuf   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_chan_en;

    function automatic logic [KW-1:0] k_of_alpha(input logic [ChanW-1:0] a);
        logic [AlphaPW-1:0]    v;
        logic [AlphaPW+15:0]   p;
        v = {{PctW{1'b0}}, a} * AlphaPW'(Percent);
        p = {16'd0, v} * {{AlphaPW{1'b0}}, RecipFull};
        return p[RecipFullSh +: KW];
    endfunction

endpackage
`default_nettype wire

/* design/argb_pixel_alpha_blend_core.sv */
// ARGB8888 pixel alpha blender: six-stage pipeline with stream ports and a register port.
//
// Usage:
//  - Pixels enter on s_axis (tdata/tuser packing at the ports) and leave on m_axis,
//    one result transaction per input transaction, in order.
//  - Configuration writes go through i_cfg_valid/o_cfg_ready with a register index
//    and data; o_cfg_ready is always high. Write only while the pipeline is empty.
//  - Throughput is one pixel per clock while m_axis_tready stays high; the six register
//    stages (scale multiply, reciprocal divide, weight multiply, channel multiply,
//    divide, add) each hold one pixel and pass it on once the next stage frees.
//  - When m_axis_tready is low, stages fill from the output back; a stage holds
//    its pixel until the next one frees, so nothing is dropped or repeated.
//    s_axis_tready drops only once all six stages are full.
//  - Synchronous active-low reset empties the pipeline and restores the register
//    defaults: solid background on, black background, line width 240, buffer 0.
`default_nettype none
module argb_pixel_alpha_blend_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [9:0] pos_x, [19:10] pos_y, [51:20] front_color, [58:52] opacity_percent,
    // [90:59] under_pixel, [95:91] zero
    input  logic [apab_pkg::SDataW-1:0]   s_axis_tdata,
    // [0] to_gray, [1] use_background
    input  logic [apab_pkg::SUserW-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] blended_pixel, [51:32] pixel_index, [55:52] zero
    output logic [apab_pkg::MDataW-1:0]   m_axis_tdata,
    // [0] target_buffer
    output logic [apab_pkg::MUserW-1:0]   m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [apab_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [apab_pkg::CfgDataW-1:0] i_cfg_data
);
    import apab_pkg::*;

    localparam int AFullW = AlphaPW + 16;
    localparam int GFullW = SumW + 10;

    // configuration
    logic              r_solid_bg;
    logic [PixW-1:0]   r_bg_color;
    logic [WidthW-1:0] r_line_width;
    logic              r_draw_buf;

    // pipeline control
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] stg_rdy;
    t_chan_en             chan_en;

    // input unpacking
    logic [CoordW-1:0] in_x;
    logic [CoordW-1:0] in_y;
    logic [PixW-1:0]   in_front;
    logic [PctW-1:0]   in_pct;
    logic [PixW-1:0]   in_under;
    logic              in_gray;
    logic              in_use_bg;

    // stage 1
    logic [AlphaPW-1:0] r1_alpha_p;
    logic [SumW-1:0]    r1_sum;
    logic [RgbW-1:0]    r1_front;
    logic [RgbW-1:0]    r1_back;
    logic               r1_gray;
    logic [IdxW-1:0]    r1_idx;
    logic               r1_tb;
    logic [IdxW-1:0]    n1_idx;
    logic [RgbW-1:0]    n1_back;

    // stage 2
    logic [ChanW-1:0]   r2_alpha;
    logic [RgbW-1:0]    r2_front;
    logic [RgbW-1:0]    r2_back;
    logic [IdxW-1:0]    r2_idx;
    logic               r2_tb;
    logic [AFullW-1:0]  n2_afull;
    logic [GFullW-1:0]  n2_gfull;
    logic [ChanW:0]     n2_a9;
    logic [ChanW-1:0]   n2_alpha;
    logic [ChanW-1:0]   n2_gray;
    logic [RgbW-1:0]    n2_front;

    // stages 3..6
    logic [KW-1:0]      r3_k;
    logic [IdxW-1:0]    r3_idx;
    logic               r3_tb;
    logic [IdxW-1:0]    r4_idx;
    logic               r4_tb;
    logic [IdxW-1:0]    r5_idx;
    logic               r5_tb;
    logic [IdxW-1:0]    r6_idx;
    logic               r6_tb;

    logic [ChanW-1:0]   out_r;
    logic [ChanW-1:0]   out_g;
    logic [ChanW-1:0]   out_b;

    assign in_x      = s_axis_tdata[9:0];
    assign in_y      = s_axis_tdata[19:10];
    assign in_front  = s_axis_tdata[51:20];
    assign in_pct    = s_axis_tdata[58:52];
    assign in_under  = s_axis_tdata[90:59];
    assign in_gray   = s_axis_tuser[0];
    assign in_use_bg = s_axis_tuser[1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid_bg   <= 1'b1;
            r_bg_color   <= '0;
            r_line_width <= LineWidthRst;
            r_draw_buf   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CfgSolidBg:   r_solid_bg   <= i_cfg_data[0];
                CfgBgColor:   r_bg_color   <= i_cfg_data;
                CfgLineWidth: r_line_width <= i_cfg_data[WidthW-1:0];
                CfgDrawBuf:   r_draw_buf   <= i_cfg_data[0];
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    always_comb begin
        stg_rdy[NumStages-1] = !r_vld[NumStages-1] || m_axis_tready;
        for (int i = NumStages - 2; i >= 0; i--) begin
            stg_rdy[i] = !r_vld[i] || stg_rdy[i+1];
        end
    end

    assign chan_en.s3 = stg_rdy[2];
    assign chan_en.s4 = stg_rdy[3];
    assign chan_en.s5 = stg_rdy[4];
    assign chan_en.s6 = stg_rdy[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NumStages; i++) begin
                if (stg_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        n1_idx  = ({{(IdxW-CoordW){1'b0}}, in_y} * {{(IdxW-WidthW){1'b0}}, r_line_width})
                  + {{(IdxW-CoordW){1'b0}}, in_x};
        n1_back = (in_use_bg && r_solid_bg) ? r_bg_color[RgbW-1:0] : in_under[RgbW-1:0];
    end

    always_comb begin
        n2_afull = {{(AFullW-AlphaPW){1'b0}}, r1_alpha_p} * {{(AFullW-16){1'b0}}, RecipPct};
        n2_a9    = n2_afull[RecipPctSh +: ChanW+1];
        n2_alpha = n2_a9[ChanW] ? 8'hFF : n2_a9[ChanW-1:0];
        n2_gfull = {{(GFullW-SumW){1'b0}}, r1_sum} * {{(GFullW-10){1'b0}}, RecipThird};
        n2_gray  = n2_gfull[RecipThirdSh +: ChanW];
        n2_front = r1_gray ? {n2_gray, n2_gray, n2_gray} : r1_front;
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r1_alpha_p <= {{PctW{1'b0}}, in_front[31:24]} * {{ChanW{1'b0}}, in_pct};
            r1_sum     <= {2'b00, in_front[23:16]} + {2'b00, in_front[15:8]}
                          + {2'b00, in_front[7:0]};
            r1_front   <= in_front[RgbW-1:0];
            r1_back    <= n1_back;
            r1_gray    <= in_gray;
            r1_idx     <= n1_idx;
            r1_tb      <= r_draw_buf;
        end
        if (stg_rdy[1]) begin
            r2_alpha <= n2_alpha;
            r2_front <= n2_front;
            r2_back  <= r1_back;
            r2_idx   <= r1_idx;
            r2_tb    <= r1_tb;
        end
        if (stg_rdy[2]) begin
            r3_k   <= k_of_alpha(r2_alpha);
            r3_idx <= r2_idx;
            r3_tb  <= r2_tb;
        end
        if (stg_rdy[3]) begin
            r4_idx <= r3_idx;
            r4_tb  <= r3_tb;
        end
        if (stg_rdy[4]) begin
            r5_idx <= r4_idx;
            r5_tb  <= r4_tb;
        end
        if (stg_rdy[5]) begin
            r6_idx <= r5_idx;
            r6_tb  <= r5_tb;
        end
    end

    apab_chan u_chan_r (
        .i_clk   (i_clk),
        .i_en    (chan_en),
        .i_front (r2_front[23:16]),
        .i_back  (r2_back[23:16]),
        .i_k     (r3_k),
        .o_ch    (out_r)
    );

    apab_chan u_chan_g (
        .i_clk   (i_clk),
        .i_en    (chan_en),
        .i_front (r2_front[15:8]),
        .i_back  (r2_back[15:8]),
        .i_k     (r3_k),
        .o_ch    (out_g)
    );

    apab_chan u_chan_b (
        .i_clk   (i_clk),
        .i_en    (chan_en),
        .i_front (r2_front[7:0]),
        .i_back  (r2_back[7:0]),
        .i_k     (r3_k),
        .o_ch    (out_b)
    );

    assign s_axis_tready = stg_rdy[0];
    assign m_axis_tvalid = r_vld[NumStages-1];
    assign m_axis_tdata  = {{(MDataW-IdxW-PixW){1'b0}}, r6_idx, AlphaOpaque, out_r, out_g, out_b};
    assign m_axis_tuser  = r6_tb;

endmodule
`default_nettype wire

/* design/apab_chan.sv */
// One color channel of the blend: difference, weight multiply, divide by 100, recombine.
`default_nettype none
module apab_chan (
    input  logic                     i_clk,
    input  apab_pkg::t_chan_en       i_en,
    input  logic [apab_pkg::ChanW-1:0] i_front,
    input  logic [apab_pkg::ChanW-1:0] i_back,
    input  logic [apab_pkg::KW-1:0]  i_k,
    output logic [apab_pkg::ChanW-1:0] o_ch
);
    import apab_pkg::*;

    localparam int ProdW = ChanW + KW;
    localparam int QW    = ProdW + 16;

    logic             r3_neg;
    logic [ChanW-1:0] r3_mag;
    logic [ChanW-1:0] r3_back;
    logic             r4_neg;
    logic [ProdW-1:0] r4_prod;
    logic [ChanW-1:0] r4_back;
    logic             r5_neg;
    logic [ChanW-1:0] r5_q;
    logic [ChanW-1:0] r5_back;
    logic [ChanW-1:0] r6_out;

    logic             n3_neg;
    logic [ChanW-1:0] n3_mag;
    logic [QW-1:0]    n5_full;
    logic [ChanW-1:0] n6_out;

    always_comb begin
        n3_neg  = i_front < i_back;
        n3_mag  = n3_neg ? (i_back - i_front) : (i_front - i_back);
        n5_full = {{(QW-ProdW){1'b0}}, r4_prod} * {{(QW-16){1'b0}}, RecipPct};
        n6_out  = r5_neg ? (r5_back - r5_q) : (r5_back + r5_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_neg  <= n3_neg;
            r3_mag  <= n3_mag;
            r3_back <= i_back;
        end
        if (i_en.s4) begin
            r4_neg  <= r3_neg;
            r4_prod <= {{KW{1'b0}}, r3_mag} * {{ChanW{1'b0}}, i_k};
            r4_back <= r3_back;
        end
        if (i_en.s5) begin
            r5_neg  <= r4_neg;
            r5_q    <= n5_full[RecipPctSh +: ChanW];
            r5_back <= r4_back;
        end
        if (i_en.s6) begin
            r6_out <= n6_out;
        end
    end

    assign o_ch = r6_out;

endmodule
`default_nettype wire

/* verif/tb_argb_pixel_alpha_blend_core.sv */
// Self-checking stream testbench for the ARGB pixel alpha blend core.
`timescale 1ns / 100ps
`default_nettype none
module tb_argb_pixel_alpha_blend_core;
    import apab_pkg::*;

    localparam int StallLimit = 2000;
    localparam int MaxReports = 10;

    typedef struct packed {
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [PixW-1:0]   front;
        logic [PctW-1:0]   pct;
        logic              to_gray;
        logic              use_bg;
        logic [PixW-1:0]   under;
    } t_pixel_req;

    typedef struct packed {
        logic [PixW-1:0] pixel;
        logic [IdxW-1:0] index;
        logic            target;
    } t_blend_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SDataW-1:0]   s_axis_tdata = '0;
    logic [SUserW-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [MDataW-1:0]   m_axis_tdata;
    logic [MUserW-1:0]   m_axis_tuser;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    // configuration as seen by the blend model
    logic              solid_mode = 1'b1;
    logic [PixW-1:0]   solid_color = '0;
    logic [WidthW-1:0] row_width = LineWidthRst;
    logic              draw_buf = 1'b0;

    t_pixel_req pixel_feed_q[$];
    t_blend_res blend_expect_q[$];

    logic s_taken = 1'b0;
    logic cfg_taken = 1'b0;
    bit   stall_en = 1'b1;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_fail = 0;
    int   idle_cycles = 0;

    argb_pixel_alpha_blend_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_blend_res predict_blend(input t_pixel_req p);
        t_blend_res res;
        int alpha, weight, gray, mag;
        int fc[3];
        int bc[3];
        int oc[3];
        logic [PixW-1:0] back;
        logic [31:0] lin;
        alpha = int'(p.front[31:24]) * int'(p.pct) / Percent;
        if (alpha > FullScale) begin
            alpha = FullScale;
        end
        weight = alpha * Percent / FullScale;
        back = (p.use_bg && solid_mode) ? solid_color : p.under;
        for (int c = 0; c < 3; c++) begin
            fc[c] = int'(p.front[8*c +: 8]);
            bc[c] = int'(back[8*c +: 8]);
        end
        if (p.to_gray) begin
            gray = (fc[0] + fc[1] + fc[2]) / 3;
            for (int c = 0; c < 3; c++) begin
                fc[c] = gray;
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (fc[c] >= bc[c]) begin
                mag = (fc[c] - bc[c]) * weight / Percent;
                oc[c] = bc[c] + mag;
            end else begin
                mag = (bc[c] - fc[c]) * weight / Percent;
                oc[c] = bc[c] - mag;
            end
        end
        res.pixel = {AlphaOpaque, oc[2][7:0], oc[1][7:0], oc[0][7:0]};
        lin = p.pos_y * row_width + p.pos_x;
        res.index = lin[IdxW-1:0];
        res.target = draw_buf;
        return res;
    endfunction

    // input driver
    always @(negedge i_clk) begin : feed
        t_pixel_req p;
        if (!s_axis_tvalid || s_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_feed_q.size() != 0) begin
                p = pixel_feed_q.pop_front();
                s_axis_tdata <= {5'd0, p.under, p.pct, p.front, p.pos_y, p.pos_x};
                s_axis_tuser <= {p.use_bg, p.to_gray};
                s_axis_tvalid <= 1'b1;
                if (stall_en && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 19);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (stall_en && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(1, 19);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : watch
        t_pixel_req req;
        t_blend_res want;
        t_blend_res got;
        s_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CfgSolidBg:   solid_mode = i_cfg_data[0];
                    CfgBgColor:   solid_color = i_cfg_data;
                    CfgLineWidth: row_width = i_cfg_data[WidthW-1:0];
                    CfgDrawBuf:   draw_buf = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.pos_x = s_axis_tdata[9:0];
                req.pos_y = s_axis_tdata[19:10];
                req.front = s_axis_tdata[51:20];
                req.pct = s_axis_tdata[58:52];
                req.under = s_axis_tdata[90:59];
                req.to_gray = s_axis_tuser[0];
                req.use_bg = s_axis_tuser[1];
                blend_expect_q.push_back(predict_blend(req));
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.pixel = m_axis_tdata[31:0];
                got.index = m_axis_tdata[51:32];
                got.target = m_axis_tuser[0];
                if (blend_expect_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MaxReports) begin
                        $display("unexpected result: pixel %08h index %05h buffer %0d",
                                 got.pixel, got.index, got.target);
                    end
                end else begin
                    want = blend_expect_q.pop_front();
                    if (got.pixel !== want.pixel || got.index !== want.index
                            || got.target !== want.target) begin
                        n_fail++;
                        if (n_fail <= MaxReports) begin
                            $display("mismatch: exp %08h/%05h/%0d got %08h/%05h/%0d",
                                     want.pixel, want.index, want.target,
                                     got.pixel, got.index, got.target);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                               input logic [PixW-1:0] front, input logic [PctW-1:0] pct,
                               input logic gray, input logic bg, input logic [PixW-1:0] under);
        t_pixel_req p;
        p.pos_x = x;
        p.pos_y = y;
        p.front = front;
        p.pct = pct;
        p.to_gray = gray;
        p.use_bg = bg;
        p.under = under;
        pixel_feed_q.push_back(p);
        n_queued++;
    endtask

    task automatic queue_random(input int count);
        logic [PixW-1:0] front;
        logic [PctW-1:0] pct;
        logic [CoordW-1:0] x, y;
        int sel;
        repeat (count) begin
            front = $urandom;
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                front[31:24] = 8'hFF;
            end else if (sel == 1) begin
                front[31:24] = 8'h00;
            end
            sel = $urandom_range(0, 15);
            if (sel < 2) begin
                pct = 7'd100;
            end else if (sel == 2) begin
                pct = 7'd0;
            end else if (sel < 5) begin
                pct = PctW'($urandom_range(101, 127));
            end else begin
                pct = PctW'($urandom_range(0, 100));
            end
            x = ($urandom_range(0, 15) == 0) ? 10'd1023 : CoordW'($urandom);
            y = ($urandom_range(0, 15) == 0) ? 10'd1023 : CoordW'($urandom);
            queue_pixel(x, y, front, pct, 1'($urandom), 1'($urandom), $urandom);
        end
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!cfg_taken);
    endtask

    task automatic apply_settings(input logic solid, input logic [PixW-1:0] color,
                                  input logic [WidthW-1:0] width, input logic dbuf);
        put_reg(CfgSolidBg, {31'd0, solid});
        put_reg(CfgBgColor, color);
        put_reg(CfgLineWidth, CfgDataW'(width));
        put_reg(CfgDrawBuf, {31'd0, dbuf});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        while (n_accepted != n_queued || blend_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (NumStages + 2) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic solid, input logic [PixW-1:0] color,
                             input logic [WidthW-1:0] width, input logic dbuf,
                             input int count);
        apply_settings(solid, color, width, dbuf);
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed pixels under reset settings
        queue_pixel(10'd0, 10'd0, 32'hFF102030, 7'd100, 1'b0, 1'b0, 32'h00000000);
        queue_pixel(10'd1023, 10'd1023, 32'h00FFFFFF, 7'd100, 1'b0, 1'b0, 32'hFF123456);
        queue_pixel(10'd5, 10'd7, 32'hFFFFFFFF, 7'd0, 1'b0, 1'b0, 32'h00000000);
        queue_pixel(10'd1, 10'd2, 32'hFF80FF01, 7'd127, 1'b0, 1'b0, 32'h00204060);
        queue_pixel(10'd3, 10'd4, 32'h80FF00FF, 7'd101, 1'b0, 1'b0, 32'h0000FF00);
        queue_pixel(10'd10, 10'd10, 32'hFFFFFFFF, 7'd100, 1'b1, 1'b0, 32'h00000000);
        queue_pixel(10'd11, 10'd10, 32'hC0010203, 7'd75, 1'b1, 1'b0, 32'hAA112233);
        queue_pixel(10'd12, 10'd10, 32'h7FFF8000, 7'd50, 1'b0, 1'b1, 32'h00FFFFFF);
        queue_pixel(10'd13, 10'd10, 32'h40000000, 7'd100, 1'b0, 1'b1, 32'h12345678);
        queue_pixel(10'd14, 10'd10, 32'h99000000, 7'd90, 1'b0, 1'b0, 32'h00FFFFFF);
        queue_pixel(10'd1023, 10'd0, 32'h01FFFFFF, 7'd100, 1'b1, 1'b1, 32'hFFFFFFFF);
        queue_pixel(10'd0, 10'd1023, 32'hFE7F7F7F, 7'd99, 1'b0, 1'b0, 32'h00808080);
        queue_pixel(10'd512, 10'd512, 32'h80AA55AA, 7'd64, 1'b1, 1'b0, 32'h55AA55AA);
        queue_pixel(10'd1023, 10'd1023, 32'hFFFFFFFF, 7'd127, 1'b1, 1'b1, 32'hFFFFFFFF);
        queue_random(100);
        wait_drained();

        run_phase(1'b1, 32'hFFFFFFFF, 11'd2047, 1'b1, 160);
        run_phase(1'b0, $urandom, 11'd0, 1'b0, 160);
        run_phase(1'b1, $urandom, 11'd1024, 1'b1, 160);
        run_phase(1'b1, 32'h00000000, 11'd1, 1'b0, 160);
        run_phase(1'b0, 32'hFFFFFFFF, WidthW'($urandom_range(1, 2047)), 1'b1, 160);
        run_phase(1'b1, $urandom, 11'd640, 1'b0, 160);
        stall_en = 1'b0;
        run_phase(1'b1, $urandom, WidthW'($urandom), 1'($urandom), 160);

        repeat (4 * NumStages) @(negedge i_clk);
        n_fail += blend_expect_q.size();
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
